// File: hw/rtl/cdse_pkg.sv
// Package with the request and result types and the calendar constants of the date editor.
package cdse_pkg;

  typedef enum logic [2:0] {
    FN_LOAD      = 3'd0,
    FN_UP        = 3'd1,
    FN_DOWN      = 3'd2,
    FN_NEXT      = 3'd3,
    FN_OPT_RIGHT = 3'd4,
    FN_OPT_LEFT  = 3'd5,
    FN_PRESS     = 3'd6
  } func_t;

  localparam logic [1:0] FIELD_WEEKDAY = 2'd0;
  localparam logic [1:0] FIELD_DAY     = 2'd1;
  localparam logic [1:0] FIELD_MONTH   = 2'd2;
  localparam logic [1:0] FIELD_YEAR    = 2'd3;

  localparam logic [2:0] WEEKDAY_MIN = 3'd1;
  localparam logic [2:0] WEEKDAY_MAX = 3'd7;
  localparam logic [4:0] DAY_MIN     = 5'd1;
  localparam logic [4:0] DAYS_LONG   = 5'd31;
  localparam logic [4:0] DAYS_SHORT  = 5'd30;
  localparam logic [4:0] DAYS_LEAP   = 5'd29;
  localparam logic [4:0] DAYS_FEB    = 5'd28;
  localparam logic [3:0] MONTH_MIN   = 4'd1;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [6:0] YEAR_MIN    = 7'd0;
  localparam logic [6:0] YEAR_MAX    = 7'd99;

  typedef struct packed {
    func_t      func;
    logic [2:0] load_weekday;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } req_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [6:0] year_out;
    logic [1:0] field_sel;
    logic       option_sel;
    logic       done_res;
    logic       cancelled;
  } res_t;

endpackage

// File: hw/rtl/calendar_date_set_editor_unit.sv
// Top level of the date set-mode editor: request register, event logic and result register.
// Each request is one knob event (load, up, down, next field, option right, option left or
// press) and gives exactly one result with the date, the selected field, the highlighted
// option and the done and cancelled flags as they stand after the event. A request is taken
// in every cycle unless the result register is full and stalled; an accepted request waits in
// the request register and moves on to the result register once that register is empty or
// being taken, with the combinational field update between them.
// Requests are applied in order, each one seeing the date left by the one before.
module calendar_date_set_editor_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cdse_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_stall,
  output cdse_pkg::res_t res_data
);

  logic           stage_valid;
  cdse_pkg::req_t stage_req;
  logic           stage_move;

  logic [2:0] weekday_reg, weekday_next;
  logic [4:0] day_reg, day_next;
  logic [3:0] month_reg, month_next;
  logic [6:0] year_reg, year_next;
  logic [1:0] field_reg, field_next;
  logic       option_reg, option_next;
  logic       session_active, session_active_next;
  logic       done_next, cancelled_next;
  logic [4:0] day_limit;

  function automatic logic [4:0] month_limit(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] lim;
    lim = cdse_pkg::DAYS_LONG;
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
      lim = cdse_pkg::DAYS_SHORT;
    end else if (m == 4'd2) begin
      lim = (y[1:0] == 2'b00) ? cdse_pkg::DAYS_LEAP : cdse_pkg::DAYS_FEB;
    end
    return lim;
  endfunction

  // The request register drains into the result register when that is empty or being taken.
  assign stage_move = stage_valid && (!res_valid || !res_stall);
  assign req_stall  = stage_valid && !stage_move;

  assign day_limit = month_limit(month_reg, year_reg);

  always_comb begin
    weekday_next        = weekday_reg;
    day_next            = day_reg;
    month_next          = month_reg;
    year_next           = year_reg;
    field_next          = field_reg;
    option_next         = option_reg;
    session_active_next = session_active;
    done_next           = 1'b0;
    cancelled_next      = 1'b0;
    if (stage_req.func == cdse_pkg::FN_LOAD) begin
      weekday_next        = stage_req.load_weekday;
      day_next            = stage_req.load_day;
      month_next          = stage_req.load_month;
      year_next           = stage_req.load_year;
      field_next          = cdse_pkg::FIELD_WEEKDAY;
      option_next         = 1'b0;
      session_active_next = 1'b1;
    end else if (session_active) begin
      case (stage_req.func)
        cdse_pkg::FN_UP: begin
          case (field_reg)
            cdse_pkg::FIELD_WEEKDAY: begin
              weekday_next = (weekday_reg < cdse_pkg::WEEKDAY_MAX) ?
                             weekday_reg + 3'd1 : cdse_pkg::WEEKDAY_MIN;
            end
            cdse_pkg::FIELD_DAY: begin
              day_next = (day_reg < day_limit) ? day_reg + 5'd1 : cdse_pkg::DAY_MIN;
            end
            cdse_pkg::FIELD_MONTH: begin
              month_next = (month_reg < cdse_pkg::MONTH_MAX) ?
                           month_reg + 4'd1 : cdse_pkg::MONTH_MIN;
            end
            default: begin
              year_next = (year_reg < cdse_pkg::YEAR_MAX) ?
                          year_reg + 7'd1 : cdse_pkg::YEAR_MIN;
            end
          endcase
        end
        cdse_pkg::FN_DOWN: begin
          case (field_reg)
            cdse_pkg::FIELD_WEEKDAY: begin
              weekday_next = (weekday_reg > cdse_pkg::WEEKDAY_MIN) ?
                             weekday_reg - 3'd1 : cdse_pkg::WEEKDAY_MAX;
            end
            cdse_pkg::FIELD_DAY: begin
              day_next = (day_reg > cdse_pkg::DAY_MIN) ? day_reg - 5'd1 : day_limit;
            end
            cdse_pkg::FIELD_MONTH: begin
              month_next = (month_reg > cdse_pkg::MONTH_MIN) ?
                           month_reg - 4'd1 : cdse_pkg::MONTH_MAX;
            end
            default: begin
              year_next = (year_reg > cdse_pkg::YEAR_MIN) ?
                          year_reg - 7'd1 : cdse_pkg::YEAR_MAX;
            end
          endcase
        end
        cdse_pkg::FN_NEXT:      field_next  = field_reg + 2'd1;
        cdse_pkg::FN_OPT_RIGHT: option_next = 1'b1;
        cdse_pkg::FN_OPT_LEFT:  option_next = 1'b0;
        cdse_pkg::FN_PRESS: begin
          done_next           = 1'b1;
          cancelled_next      = !option_reg;
          session_active_next = 1'b0;
        end
        default: begin
        end
      endcase
      // A month change pulls the day down to the new month's length.
      if ((stage_req.func == cdse_pkg::FN_UP || stage_req.func == cdse_pkg::FN_DOWN) &&
          field_reg == cdse_pkg::FIELD_MONTH &&
          day_reg > month_limit(month_next, year_reg)) begin
        day_next = month_limit(month_next, year_reg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      res_valid      <= 1'b0;
      weekday_reg    <= 3'd1;
      day_reg        <= 5'd1;
      month_reg      <= 4'd1;
      year_reg       <= 7'd0;
      field_reg      <= 2'd0;
      option_reg     <= 1'b0;
      session_active <= 1'b0;
    end else begin
      if (!stage_valid || stage_move) begin
        stage_valid <= req_valid;
      end
      if (stage_move) begin
        res_valid      <= 1'b1;
        weekday_reg    <= weekday_next;
        day_reg        <= day_next;
        month_reg      <= month_next;
        year_reg       <= year_next;
        field_reg      <= field_next;
        option_reg     <= option_next;
        session_active <= session_active_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stage_valid || stage_move) begin
      stage_req <= req_data;
    end
    if (stage_move) begin
      res_data.weekday    <= weekday_next;
      res_data.day_out    <= day_next;
      res_data.month_out  <= month_next;
      res_data.year_out   <= year_next;
      res_data.field_sel  <= field_next;
      res_data.option_sel <= option_next;
      res_data.done_res   <= done_next;
      res_data.cancelled  <= cancelled_next;
    end
  end

endmodule

// File: hw/rtl/cdse_checker.sv
// Port-level checks for the date editor and the bind that attaches them to the top level.
module cdse_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input cdse_pkg::req_t req_data,
  input logic           res_valid,
  input logic           res_stall,
  input cdse_pkg::res_t res_data
);

  // A stalled result holds its place and its value.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed or vanished");

  // Only a press that ends a session may report a cancel.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.cancelled && !res_data.done_res))
    else $error("cancelled flag without done");

  // Requests are held back only while a finished result waits to be taken.
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request stalled with the result side free");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A request is always taken while no result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !res_valid |-> !req_stall)
    else $error("request stalled with no result pending");

endmodule

bind calendar_date_set_editor_unit cdse_checker u_cdse_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

// File: tb/tb.sv
// Self-checking testbench for the date set-mode editor: queued knob events, prediction, result check.
`timescale 1ns / 100ps

module tb;

  localparam int        LIMIT_CYCLES = 150000;
  localparam int        CALM_TAIL    = 150;
  localparam int        RANDOM_UNTIL = 1450;
  localparam logic [2:0] FN_SPARE    = 3'd7;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cdse_pkg::req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  cdse_pkg::res_t res_data;

  calendar_date_set_editor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  cdse_pkg::req_t queued_events[$];
  cdse_pkg::res_t due_readouts[$];

  int total_events = 0;
  int sent_count   = 0;
  int shown_count  = 0;
  int fail_count   = 0;
  int cycle_count  = 0;
  int directed_len = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  cdse_pkg::res_t readout_now;
  cdse_pkg::res_t readout_due;

  // Predicted editor state, at its reset values.
  logic [2:0] cur_weekday = cdse_pkg::WEEKDAY_MIN;
  logic [4:0] cur_day     = cdse_pkg::DAY_MIN;
  logic [3:0] cur_month   = cdse_pkg::MONTH_MIN;
  logic [6:0] cur_year    = cdse_pkg::YEAR_MIN;
  logic [1:0] cur_field   = cdse_pkg::FIELD_WEEKDAY;
  logic       cur_option  = 1'b0;
  logic       in_session  = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [4:0] days_in_month(logic [3:0] m, logic [6:0] y);
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) return cdse_pkg::DAYS_SHORT;
    if (m == 4'd2) return (y[1:0] == 2'd0) ? cdse_pkg::DAYS_LEAP : cdse_pkg::DAYS_FEB;
    return cdse_pkg::DAYS_LONG;
  endfunction

  // Wraps to the other end from anywhere at or beyond the end of the range.
  function automatic int knob_step(int v, int lo, int hi, bit up);
    if (up) return (v < hi) ? v + 1 : lo;
    return (v > lo) ? v - 1 : hi;
  endfunction

  task automatic predict_readout(input cdse_pkg::req_t rq, output cdse_pkg::res_t rs);
    logic [4:0] lim;
    bit         is_up;
    rs = '0;
    if (rq.func == cdse_pkg::FN_LOAD) begin
      cur_weekday = rq.load_weekday;
      cur_day     = rq.load_day;
      cur_month   = rq.load_month;
      cur_year    = rq.load_year;
      cur_field   = cdse_pkg::FIELD_WEEKDAY;
      cur_option  = 1'b0;
      in_session  = 1'b1;
    end else if (in_session) begin
      case (rq.func)
        cdse_pkg::FN_UP, cdse_pkg::FN_DOWN: begin
          is_up = (rq.func == cdse_pkg::FN_UP);
          case (cur_field)
            cdse_pkg::FIELD_WEEKDAY: begin
              cur_weekday = 3'(knob_step(int'(cur_weekday), int'(cdse_pkg::WEEKDAY_MIN),
                                         int'(cdse_pkg::WEEKDAY_MAX), is_up));
            end
            cdse_pkg::FIELD_DAY: begin
              lim = days_in_month(cur_month, cur_year);
              cur_day = 5'(knob_step(int'(cur_day), int'(cdse_pkg::DAY_MIN), int'(lim),
                                     is_up));
            end
            cdse_pkg::FIELD_MONTH: begin
              cur_month = 4'(knob_step(int'(cur_month), int'(cdse_pkg::MONTH_MIN),
                                       int'(cdse_pkg::MONTH_MAX), is_up));
              lim = days_in_month(cur_month, cur_year);
              if (cur_day > lim) cur_day = lim;
            end
            default: begin
              cur_year = 7'(knob_step(int'(cur_year), int'(cdse_pkg::YEAR_MIN),
                                      int'(cdse_pkg::YEAR_MAX), is_up));
            end
          endcase
        end
        cdse_pkg::FN_NEXT:      cur_field = cur_field + 2'd1;
        cdse_pkg::FN_OPT_RIGHT: cur_option = 1'b1;
        cdse_pkg::FN_OPT_LEFT:  cur_option = 1'b0;
        cdse_pkg::FN_PRESS: begin
          rs.done_res  = 1'b1;
          rs.cancelled = ~cur_option;
          in_session   = 1'b0;
        end
        default: ;
      endcase
    end
    rs.weekday    = cur_weekday;
    rs.day_out    = cur_day;
    rs.month_out  = cur_month;
    rs.year_out   = cur_year;
    rs.field_sel  = cur_field;
    rs.option_sel = cur_option;
  endtask

  task automatic queue_load(logic [2:0] wd, logic [4:0] dy, logic [3:0] mo, logic [6:0] yr);
    cdse_pkg::req_t rq;
    rq.func         = cdse_pkg::FN_LOAD;
    rq.load_weekday = wd;
    rq.load_day     = dy;
    rq.load_month   = mo;
    rq.load_year    = yr;
    queued_events.push_back(rq);
  endtask

  // The load fields are don't-care for every event but a load, so they carry random noise.
  task automatic queue_event(cdse_pkg::func_t f);
    cdse_pkg::req_t rq;
    rq.func         = f;
    rq.load_weekday = 3'($urandom_range(0, 7));
    rq.load_day     = 5'($urandom_range(0, 31));
    rq.load_month   = 4'($urandom_range(0, 15));
    rq.load_year    = 7'($urandom_range(0, 127));
    queued_events.push_back(rq);
  endtask

  task automatic queue_session();
    logic [3:0]      mo;
    logic [6:0]      yr;
    logic [4:0]      lim;
    cdse_pkg::func_t f;
    int              pick;
    int              reps;
    int              picks;
    if ($urandom_range(0, 9) != 0) begin
      mo  = 4'($urandom_range(1, 12));
      yr  = 7'($urandom_range(0, 99));
      lim = days_in_month(mo, yr);
      queue_load(3'($urandom_range(1, 7)),
                 ($urandom_range(0, 2) == 0) ? lim : 5'($urandom_range(1, lim)), mo, yr);
    end else begin
      queue_event(cdse_pkg::FN_LOAD);
    end
    picks = $urandom_range(2, 20);
    repeat (picks) begin
      pick = $urandom_range(0, 99);
      if (pick < 34)      f = cdse_pkg::FN_UP;
      else if (pick < 58) f = cdse_pkg::FN_DOWN;
      else if (pick < 74) f = cdse_pkg::FN_NEXT;
      else if (pick < 82) f = cdse_pkg::FN_OPT_RIGHT;
      else if (pick < 90) f = cdse_pkg::FN_OPT_LEFT;
      else if (pick < 94) f = cdse_pkg::func_t'(FN_SPARE);
      else if (pick < 97) f = cdse_pkg::FN_PRESS;
      else                f = cdse_pkg::FN_LOAD;
      reps = (f == cdse_pkg::FN_UP || f == cdse_pkg::FN_DOWN) ? $urandom_range(1, 4) : 1;
      repeat (reps) queue_event(f);
    end
    if ($urandom_range(0, 99) < 85) queue_event(cdse_pkg::FN_PRESS);
    repeat ($urandom_range(0, 2)) queue_event(cdse_pkg::func_t'($urandom_range(1, 7)));
  endtask

  // Stimulus, then wait for the last readout and a short drain.
  initial begin
    queue_event(cdse_pkg::FN_UP);                      // ignored, no session yet
    queue_event(cdse_pkg::func_t'(FN_SPARE));
    queue_load(3'd7, 5'd31, 4'd1, 7'd99);
    queue_event(cdse_pkg::FN_UP);                      // weekday wraps from 7 to 1
    queue_event(cdse_pkg::FN_DOWN);
    queue_event(cdse_pkg::FN_NEXT);
    queue_event(cdse_pkg::FN_UP);                      // day wraps at 31
    queue_event(cdse_pkg::FN_DOWN);
    queue_event(cdse_pkg::FN_NEXT);
    queue_event(cdse_pkg::FN_UP);          // February of a common year clamps the day
    queue_event(cdse_pkg::FN_OPT_RIGHT);
    queue_event(cdse_pkg::FN_OPT_RIGHT);   // already at the end of the option knob
    queue_event(cdse_pkg::FN_PRESS);                   // confirmed
    queue_event(cdse_pkg::FN_DOWN);                    // ignored after the press
    queue_load(3'd0, 5'd31, 4'd2, 7'd0);   // weekday out of range, day above the leap limit
    queue_event(cdse_pkg::FN_NEXT);
    queue_event(cdse_pkg::FN_UP);
    queue_event(cdse_pkg::FN_NEXT);
    queue_event(cdse_pkg::FN_NEXT);
    queue_event(cdse_pkg::FN_DOWN);                    // year wraps to 99
    queue_event(cdse_pkg::func_t'(FN_SPARE));
    queue_event(cdse_pkg::FN_OPT_LEFT);
    queue_load(3'd7, 5'd0, 4'd15, 7'd127);             // reload during a session
    queue_event(cdse_pkg::FN_DOWN);
    queue_event(cdse_pkg::FN_PRESS);                   // cancelled
    directed_len = queued_events.size();
    while (queued_events.size() < RANDOM_UNTIL) queue_session();
    total_events = queued_events.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_events || due_readouts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && due_readouts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Request driver. The sender also holds back twice until every readout is in.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_readout(req_data, readout_now);
        due_readouts.push_back(readout_now);
        sent_count++;
      end
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (queued_events.size() == 0 ||
                     ((sent_count == directed_len || sent_count == total_events / 2) &&
                      due_readouts.size() != 0)) begin
          req_valid <= 1'b0;
        end else begin
          req_data  <= queued_events.pop_front();
          req_valid <= 1'b1;
          if (queued_events.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 6);
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_readouts.size() == 0) begin
          $error("readout with no request outstanding");
          fail_count++;
        end else begin
          readout_due = due_readouts.pop_front();
          check_field("weekday", int'(readout_due.weekday), int'(res_data.weekday));
          check_field("day_out", int'(readout_due.day_out), int'(res_data.day_out));
          check_field("month_out", int'(readout_due.month_out), int'(res_data.month_out));
          check_field("year_out", int'(readout_due.year_out), int'(res_data.year_out));
          check_field("field_sel", int'(readout_due.field_sel), int'(res_data.field_sel));
          check_field("option_sel", int'(readout_due.option_sel),
                      int'(res_data.option_sel));
          check_field("done_res", int'(readout_due.done_res), int'(res_data.done_res));
          check_field("cancelled", int'(readout_due.cancelled), int'(res_data.cancelled));
        end
        shown_count++;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (shown_count < total_events - CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
